### hdl/lsr_pkg.sv
package lsr_pkg;

	localparam int CHAR_W    = 8;
	localparam int REG_CHARS = 8;
	localparam int CNT_W     = 4;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = $clog2(REG_CHARS);
	localparam int REG_IDX_W = 3;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_BYTES,
		REG_PATTERN_LENGTH,
		REG_REPLACEMENT_BYTES,
		REG_REPLACEMENT_LENGTH,
		REG_CASE_SENSITIVE,
		REG_REPLACE_ONCE,
		REG_WHOLE_TEXT
	} reg_idx_t;

	typedef struct packed {
		char_t in_char;
		logic  end_of_name;
	} in_t;

	typedef struct packed {
		char_t out_char;
		logic  char_valid;
		logic  name_matched;
		logic  last_of_name;
	} out_t;

	// lengths are already limited to the window sizes
	typedef struct packed {
		cnt_t plen;
		cnt_t rlen;
		logic case_sensitive;
		logic replace_once;
		logic whole_text;
	} ctl_t;

	// one accepted character turns into: chars[0..nchars) then the replacement
	typedef struct packed {
		char_t [REG_CHARS-1:0] chars;
		cnt_t                  nchars;
		cnt_t                  nres;
		logic                  bare;
		logic                  eon;
		logic                  matched;
	} cmd_t;

	function automatic char_t fold(input char_t c, input logic on);
		char_t r;
		r = c;
		if (on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

### hdl/lsr_queue.sv
module lsr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lsr_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output lsr_pkg::cmd_t dout,
	output logic          valid
);
	import lsr_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/lsr_front.sv
module lsr_front #(
	parameter int PWIN = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  lsr_pkg::in_t                        req,
	input  lsr_pkg::ctl_t                       ctl,
	input  logic [PWIN-1:0][lsr_pkg::CHAR_W-1:0] pat,
	output logic                                push,
	output lsr_pkg::cmd_t                       cmd
);
	import lsr_pkg::*;

	localparam logic [CNT_W:0] TOT_MAX = (CNT_W+1)'(REG_CHARS);

	char_t          win_q [PWIN];
	cnt_t           cnt_q;
	logic           replaced_q;
	logic           too_long_q;

	char_t          ext [PWIN];
	char_t          win_n [PWIN];
	cnt_t           m;
	logic           fold_on;
	logic [PWIN:0]  ok;
	cnt_t           d_sel;
	cnt_t           rem;
	logic           hit;
	logic           eon;

	cnt_t           sh;
	cnt_t           cnt_n;
	logic           replaced_n;
	logic           too_long_n;
	cnt_t           nchars;
	logic           rep;
	logic           single_c;
	logic           once_list;
	cnt_t           rep_n;
	logic [CNT_W:0] total;

	assign eon     = req.end_of_name;
	assign m       = cnt_q + cnt_t'(1);
	assign fold_on = ctl.whole_text | ~ctl.case_sensitive;

	// held characters with the new one appended
	always_comb begin
		for (int k = 0; k < PWIN; k++) begin
			ext[k] = (cnt_t'(k) < cnt_q) ? win_q[k] : req.in_char;
		end
	end

	// ok[d]: dropping d leading characters leaves a prefix of the pattern
	always_comb begin
		for (int d = 0; d <= PWIN; d++) begin
			ok[d] = (cnt_t'(d) <= m) && ((m - cnt_t'(d)) <= ctl.plen);
			for (int i = 0; i < PWIN - d; i++) begin
				if ((cnt_t'(i) < (m - cnt_t'(d))) &&
				    (fold(ext[d+i], fold_on) != fold(pat[i], fold_on))) begin
					ok[d] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		d_sel = cnt_t'(PWIN);
		for (int d = PWIN; d >= 0; d--) begin
			if (ok[d]) begin
				d_sel = cnt_t'(d);
			end
		end
	end

	assign rem = m - d_sel;
	assign hit = (rem == ctl.plen);

	always_comb begin
		sh         = '0;
		cnt_n      = cnt_q;
		replaced_n = replaced_q;
		too_long_n = too_long_q;
		nchars     = '0;
		rep        = 1'b0;
		single_c   = 1'b0;
		once_list  = 1'b0;
		if (ctl.plen == '0) begin
			if (ctl.rlen == '0) begin
				single_c   = 1'b1;
				nchars     = cnt_t'(1);
				replaced_n = 1'b1;
			end else begin
				// swallow the name, emit the replacement at its end
				cnt_n = '0;
				if (eon) begin
					rep        = 1'b1;
					replaced_n = 1'b1;
				end
			end
		end else if (ctl.whole_text) begin
			if (too_long_q) begin
				single_c = 1'b1;
				nchars   = cnt_t'(1);
			end else if (ok[0] && m == ctl.plen && eon) begin
				cnt_n      = '0;
				rep        = 1'b1;
				replaced_n = 1'b1;
			end else if (!ok[0] || m >= ctl.plen || eon) begin
				// release the held characters and pass the rest through
				nchars     = m;
				cnt_n      = '0;
				too_long_n = 1'b1;
			end else begin
				cnt_n = m;
			end
		end else if (ctl.replace_once && replaced_q) begin
			once_list = 1'b1;
			nchars    = eon ? m : cnt_t'(1);
		end else begin
			sh = d_sel;
			if (hit) begin
				nchars     = d_sel;
				rep        = 1'b1;
				replaced_n = 1'b1;
				cnt_n      = '0;
			end else begin
				nchars = eon ? m : d_sel;
				cnt_n  = rem;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < PWIN; k++) begin
			win_n[k] = ext[k];
			for (int j = 0; j < PWIN; j++) begin
				if (cnt_t'(j) == cnt_t'(k) + sh) begin
					win_n[k] = ext[j];
				end
			end
		end
	end

	assign rep_n = rep ? ctl.rlen : '0;
	assign total = {1'b0, nchars} + {1'b0, rep_n};

	always_comb begin
		for (int k = 0; k < REG_CHARS; k++) begin
			cmd.chars[k] = '0;
			if (single_c) begin
				if (k == 0) begin
					cmd.chars[k] = req.in_char;
				end
			end else if (once_list) begin
				if (k == 0) begin
					cmd.chars[k] = req.in_char;
				end else if (k - 1 < PWIN) begin
					cmd.chars[k] = win_q[k-1];
				end
			end else if (k < PWIN) begin
				cmd.chars[k] = ext[k];
			end
		end
		cmd.nchars  = nchars;
		cmd.bare    = (total == '0);
		if (total == '0) begin
			cmd.nres = cnt_t'(1);
		end else if (total > TOT_MAX) begin
			cmd.nres = cnt_t'(REG_CHARS);
		end else begin
			cmd.nres = total[CNT_W-1:0];
		end
		cmd.eon     = eon;
		cmd.matched = eon & replaced_n;
	end

	// characters that cause no result and do not end the name need no request
	assign push = accept && (eon || total != '0);

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < PWIN; k++) begin
				win_q[k] <= win_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			replaced_q <= 1'b0;
			too_long_q <= 1'b0;
		end else if (accept) begin
			cnt_q      <= eon ? '0 : cnt_n;
			replaced_q <= eon ? 1'b0 : replaced_n;
			too_long_q <= eon ? 1'b0 : too_long_n;
		end
	end

endmodule

### hdl/lsr_back.sv
module lsr_back #(
	parameter int RWIN = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsr_pkg::cmd_t                       head,
	input  logic                                head_valid,
	output logic                                pop,
	input  logic [RWIN-1:0][lsr_pkg::CHAR_W-1:0] rep,
	input  logic                                stall,
	output logic                                valid,
	output lsr_pkg::out_t                       data
);
	import lsr_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	out_t             data_q;

	cnt_t             pos;
	cnt_t             j;
	char_t            ch;
	logic             last_idx;
	logic             load;
	out_t             res;

	assign pos = cnt_t'(idx_q);
	assign j   = pos - head.nchars;

	always_comb begin
		ch = '0;
		if (pos < head.nchars) begin
			ch = head.chars[idx_q];
		end else begin
			for (int k = 0; k < RWIN; k++) begin
				if (j == cnt_t'(k)) begin
					ch = rep[k];
				end
			end
		end
	end

	assign last_idx = (pos == head.nres - cnt_t'(1));

	always_comb begin
		res.out_char     = head.bare ? '0 : ch;
		res.char_valid   = ~head.bare;
		res.last_of_name = head.eon & last_idx;
		res.name_matched = head.matched & last_idx;
	end

	assign load = head_valid && (!valid_q || !stall);
	assign pop  = load && last_idx;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= last_idx ? '0 : idx_q + IDX_W'(1);
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

### hdl/literal_search_replace_stream.sv
// Path: the results of a character pass through the command queue and then the output register.
// Throughput: the back end delivers one result per cycle while rsp_stall is low; a character
// holds it until all of its results are loaded, and requests are taken each cycle while the
// two-entry command queue between front and back has room.
// Reset: asynchronous, active low; clears the held window count, the name flags, the queue
// and the output valid flag, and returns the registers to their reset values.
module literal_search_replace_stream #(
	parameter int PATTERN_MAX = 8,
	parameter int REPLACE_MAX = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  lsr_pkg::in_t                      req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output lsr_pkg::out_t                     rsp_data,
	input  logic                              cfg_we,
	input  logic [lsr_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [lsr_pkg::CFG_W-1:0]         cfg_data
);
	import lsr_pkg::*;

	localparam int PWIN = (PATTERN_MAX < REG_CHARS) ? PATTERN_MAX : REG_CHARS;
	localparam int RWIN = (REPLACE_MAX < REG_CHARS) ? REPLACE_MAX : REG_CHARS;

	logic [PWIN-1:0][CHAR_W-1:0] pat_q;
	logic [RWIN-1:0][CHAR_W-1:0] rep_q;
	cnt_t                        plen_q;
	cnt_t                        rlen_q;
	logic                        case_q;
	logic                        once_q;
	logic                        whole_q;

	ctl_t ctl;
	logic accept;
	logic push;
	cmd_t cmd;
	logic q_full;
	logic q_valid;
	logic pop;
	cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= '0;
			rep_q   <= '0;
			plen_q  <= '0;
			rlen_q  <= '0;
			case_q  <= 1'b1;
			once_q  <= 1'b0;
			whole_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_BYTES:      pat_q   <= cfg_data[PWIN*CHAR_W-1:0];
				REG_PATTERN_LENGTH:     plen_q  <= cfg_data[CNT_W-1:0];
				REG_REPLACEMENT_BYTES:  rep_q   <= cfg_data[RWIN*CHAR_W-1:0];
				REG_REPLACEMENT_LENGTH: rlen_q  <= cfg_data[CNT_W-1:0];
				REG_CASE_SENSITIVE:     case_q  <= cfg_data[0];
				REG_REPLACE_ONCE:       once_q  <= cfg_data[0];
				REG_WHOLE_TEXT:         whole_q <= cfg_data[0];
				default:                ;
			endcase
		end
	end

	always_comb begin
		ctl.plen           = (plen_q > cnt_t'(PWIN)) ? cnt_t'(PWIN) : plen_q;
		ctl.rlen           = (rlen_q > cnt_t'(RWIN)) ? cnt_t'(RWIN) : rlen_q;
		ctl.case_sensitive = case_q;
		ctl.replace_once   = once_q;
		ctl.whole_text     = whole_q;
	end

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	lsr_front #(
		.PWIN(PWIN)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.req   (req_data),
		.ctl   (ctl),
		.pat   (pat_q),
		.push  (push),
		.cmd   (cmd)
	);

	lsr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cmd),
		.full  (q_full),
		.pop   (pop),
		.dout  (head),
		.valid (q_valid)
	);

	lsr_back #(
		.RWIN(RWIN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(q_valid),
		.pop       (pop),
		.rep       (rep_q),
		.stall     (rsp_stall),
		.valid     (rsp_valid),
		.data      (rsp_data)
	);

`ifndef ASSERT_OFF
	a_matched_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last_of_name |-> !rsp_data.name_matched)
		else $error("name_matched set on a result that does not end the name");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.char_valid |-> rsp_data.last_of_name && rsp_data.out_char == '0)
		else $error("bare marker is not a clean end of name");

	a_back_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !rsp_valid |=> rsp_valid)
		else $error("queued request not moved to the output register");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into a full queue");
`endif

endmodule
